FILE: rtl/akf_pkg.sv
//------------------------------------------------------------------------------
// akf_pkg
// Shared types and constants for the three-axis angle/bias Kalman filter.
//------------------------------------------------------------------------------
package akf_pkg;

	localparam int AXES = 3;
	localparam int AXW  = 2;

	localparam logic [30:0] QA_RST = 31'd167772;
	localparam logic [30:0] QB_RST = 31'd50332;
	localparam logic [30:0] RM_RST = 31'd50332;

	// configuration register indexes
	localparam logic [1:0] REG_QA = 2'd0;
	localparam logic [1:0] REG_QB = 2'd1;
	localparam logic [1:0] REG_RM = 2'd2;

	// sequencer steps
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_M_ANG,   // dt*(rate-bias)
		ST_M_BB,    // dt*bb
		ST_M_ABBA,  // -dt*(ab+ba)
		ST_M_QA,    // qa*dt
		ST_M_QB,    // qb*dt
		ST_PRED,    // write back predicted values
		ST_DIV0,    // start K0 division
		ST_WAIT0,
		ST_DIV1,
		ST_WAIT1,
		ST_C_K0E,
		ST_C_K1E,
		ST_C_K0AA,
		ST_C_K0AB,
		ST_C_K1AA,
		ST_C_K1AB,
		ST_STORE,
		ST_OUT
	} state_t;

	// saturate a 66-bit signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -66'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

endpackage

FILE: rtl/akf_div.sv
//------------------------------------------------------------------------------
// akf_div
// Radix-2 restoring divider: signed 57-bit numerator / positive-or-negative
// 34-bit denominator, quotient truncated toward zero, one bit per cycle.
//------------------------------------------------------------------------------
module akf_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [56:0]  num,
	input  logic signed [33:0]  den,
	output logic                done,
	output logic signed [57:0]  quo
);

	logic [56:0] nq_q;     // numerator magnitude shifting into quotient
	logic [33:0] rem_q;
	logic [33:0] dm_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [34:0] trial;

	assign trial = {rem_q, nq_q[56]} - {1'b0, dm_q};

	// one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd57;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num[56] ? 57'(-num) : num;
			dm_q  <= den[33] ? 34'(-den) : den;
			neg_q <= num[56] ^ den[33];
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[34]) begin
				rem_q <= trial[33:0];
				nq_q  <= {nq_q[55:0], 1'b1};
			end else begin
				rem_q <= {rem_q[32:0], nq_q[56]};
				nq_q  <= {nq_q[55:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? -$signed({1'b0, nq_q}) : $signed({1'b0, nq_q});

endmodule

FILE: rtl/akf_mul.sv
//------------------------------------------------------------------------------
// akf_mul
// Shared signed 33x33 multiplier with registered product and floor >>24.
//------------------------------------------------------------------------------
module akf_mul (
	input  logic               clk,
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic signed [41:0] p_sh
);

	logic signed [65:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	// arithmetic shift rounds toward minus infinity
	assign p_sh = 42'(prod_q >>> 24);

endmodule

FILE: rtl/angle_kalman_filter_three_axis.sv
//------------------------------------------------------------------------------
// angle_kalman_filter_three_axis
// Per-axis two-state (angle, gyro bias) Kalman filter, fixed point.
//------------------------------------------------------------------------------
// One request is handled at a time: each item runs two passes of the
// bit-serial 57-step divider for the gains plus eleven steps of the shared
// multiplier. Requests
// with an axis of three or more are dropped without a result. The result
// stays in an output register until taken; a new request is accepted once
// the result has left.
module angle_kalman_filter_three_axis (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [30:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          axis,
	input  logic signed [31:0]  measured_angle,
	input  logic signed [31:0]  gyro_rate,
	input  logic [23:0]         time_step,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          axis_out,
	output logic signed [31:0]  filtered_angle,
	output logic signed [31:0]  estimated_bias
);

	akf_pkg::state_t st_q, st_d;

	logic [30:0] qa_q, qb_q, rm_q;
	logic signed [31:0] ang_r [akf_pkg::AXES];
	logic signed [31:0] bia_r [akf_pkg::AXES];
	logic signed [31:0] aa_r  [akf_pkg::AXES];
	logic signed [31:0] ab_r  [akf_pkg::AXES];
	logic signed [31:0] ba_r  [akf_pkg::AXES];
	logic signed [31:0] bb_r  [akf_pkg::AXES];

	logic [1:0]         ax_q;
	logic signed [31:0] meas_q, rate_q;
	logic [23:0]        dt_q;
	logic signed [31:0] ang_q, bia_q, aa_q, ab_q, ba_q, bb_q;
	logic signed [41:0] t_ang_q, t_bb_q, t_abba_q, t_qa_q;
	logic signed [31:0] k0_q, k1_q;
	logic signed [32:0] e_q;

	logic               accept;
	logic signed [32:0] ma, mb;
	logic signed [41:0] p_sh;
	logic               dv_start, dv_done;
	logic signed [56:0] dv_num;
	logic signed [33:0] dv_den;
	logic signed [57:0] dv_quo;
	logic signed [31:0] k_sat;

	assign in_stall = (st_q != akf_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q <= akf_pkg::QA_RST;
			qb_q <= akf_pkg::QB_RST;
			rm_q <= akf_pkg::RM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				akf_pkg::REG_QA: qa_q <= cfg_data;
				akf_pkg::REG_QB: qb_q <= cfg_data;
				akf_pkg::REG_RM: rm_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// multiplier operand select, one product per step
	always_comb begin
		ma = 33'(signed'({1'b0, dt_q}));
		mb = '0;
		case (st_q)
			akf_pkg::ST_M_ANG:  mb = 33'(rate_q) - 33'(bia_q);
			akf_pkg::ST_M_BB:   mb = 33'(bb_q);
			// negated time step gives -(dt*(ab+ba)) before the floor shift
			akf_pkg::ST_M_ABBA: begin
				ma = 33'sd0 - 33'(signed'({1'b0, dt_q}));
				mb = 33'(ab_q) + 33'(ba_q);
			end
			akf_pkg::ST_M_QA:   mb = 33'(signed'({1'b0, qa_q}));
			akf_pkg::ST_M_QB:   mb = 33'(signed'({1'b0, qb_q}));
			akf_pkg::ST_C_K0E:  begin ma = 33'(k0_q); mb = e_q; end
			akf_pkg::ST_C_K1E:  begin ma = 33'(k1_q); mb = e_q; end
			akf_pkg::ST_C_K0AA: begin ma = 33'(k0_q); mb = 33'(aa_q); end
			akf_pkg::ST_C_K0AB: begin ma = 33'(k0_q); mb = 33'(ab_q); end
			akf_pkg::ST_C_K1AA: begin ma = 33'(k1_q); mb = 33'(aa_q); end
			akf_pkg::ST_C_K1AB: begin ma = 33'(k1_q); mb = 33'(ab_q); end
			default: ;
		endcase
	end

	akf_mul u_mul (.clk(clk), .a(ma), .b(mb), .p_sh(p_sh));

	// signed numerator covariance * 2^24
	assign dv_start = (st_q == akf_pkg::ST_DIV0) || (st_q == akf_pkg::ST_DIV1);
	assign dv_num   = (st_q == akf_pkg::ST_DIV0) ? {aa_q[31], aa_q, 24'd0}
	                                             : {ba_q[31], ba_q, 24'd0};
	assign dv_den   = 34'(aa_q) + 34'(signed'({1'b0, rm_q}));

	akf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .num(dv_num),
		.den(dv_den), .done(dv_done), .quo(dv_quo)
	);

	// zero innovation variance gives zero gain
	assign k_sat = (dv_den == '0) ? '0 : akf_pkg::sat32(66'(dv_quo));

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			akf_pkg::ST_IDLE:
				if (accept && (32'(axis) < akf_pkg::AXES)) st_d = akf_pkg::ST_M_ANG;
			akf_pkg::ST_M_ANG:  st_d = akf_pkg::ST_M_BB;
			akf_pkg::ST_M_BB:   st_d = akf_pkg::ST_M_ABBA;
			akf_pkg::ST_M_ABBA: st_d = akf_pkg::ST_M_QA;
			akf_pkg::ST_M_QA:   st_d = akf_pkg::ST_M_QB;
			akf_pkg::ST_M_QB:   st_d = akf_pkg::ST_PRED;
			akf_pkg::ST_PRED:   st_d = akf_pkg::ST_DIV0;
			akf_pkg::ST_DIV0:   st_d = akf_pkg::ST_WAIT0;
			akf_pkg::ST_WAIT0:  if (dv_done) st_d = akf_pkg::ST_DIV1;
			akf_pkg::ST_DIV1:   st_d = akf_pkg::ST_WAIT1;
			akf_pkg::ST_WAIT1:  if (dv_done) st_d = akf_pkg::ST_C_K0E;
			akf_pkg::ST_C_K0E:  st_d = akf_pkg::ST_C_K1E;
			akf_pkg::ST_C_K1E:  st_d = akf_pkg::ST_C_K0AA;
			akf_pkg::ST_C_K0AA: st_d = akf_pkg::ST_C_K0AB;
			akf_pkg::ST_C_K0AB: st_d = akf_pkg::ST_C_K1AA;
			akf_pkg::ST_C_K1AA: st_d = akf_pkg::ST_C_K1AB;
			akf_pkg::ST_C_K1AB: st_d = akf_pkg::ST_STORE;
			akf_pkg::ST_STORE:  st_d = akf_pkg::ST_OUT;
			akf_pkg::ST_OUT:    if (!out_stall) st_d = akf_pkg::ST_IDLE;
			default:            st_d = akf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= akf_pkg::ST_IDLE;
		else         st_q <= st_d;
	end

	assign out_valid = (st_q == akf_pkg::ST_OUT);

	// datapath; the product of a step is taken in the step after it
	always_ff @(posedge clk) begin
		case (st_q)
			akf_pkg::ST_IDLE: if (accept) begin
				ax_q   <= axis;
				meas_q <= measured_angle;
				rate_q <= gyro_rate;
				dt_q   <= time_step;
				if (32'(axis) < akf_pkg::AXES) begin
					ang_q <= ang_r[axis];
					bia_q <= bia_r[axis];
					aa_q  <= aa_r[axis];
					ab_q  <= ab_r[axis];
					ba_q  <= ba_r[axis];
					bb_q  <= bb_r[axis];
				end
			end
			akf_pkg::ST_M_BB:   t_ang_q  <= p_sh;
			akf_pkg::ST_M_ABBA: t_bb_q   <= p_sh;
			akf_pkg::ST_M_QA:   t_abba_q <= p_sh;
			akf_pkg::ST_M_QB:   t_qa_q   <= p_sh;
			akf_pkg::ST_PRED: begin
				ang_q <= akf_pkg::sat32(66'(ang_q) + 66'(t_ang_q));
				aa_q  <= akf_pkg::sat32(66'(aa_q) + 66'(t_abba_q) + 66'(t_qa_q));
				ab_q  <= akf_pkg::sat32(66'(ab_q) - 66'(t_bb_q));
				ba_q  <= akf_pkg::sat32(66'(ba_q) - 66'(t_bb_q));
				bb_q  <= akf_pkg::sat32(66'(bb_q) + 66'(p_sh));
			end
			akf_pkg::ST_DIV0: e_q <= 33'(meas_q) - 33'(ang_q);
			akf_pkg::ST_WAIT0: if (dv_done) k0_q <= k_sat;
			akf_pkg::ST_WAIT1: if (dv_done) k1_q <= k_sat;
			akf_pkg::ST_C_K1E:
				ang_q <= akf_pkg::sat32(66'(ang_q) + 66'(p_sh));
			akf_pkg::ST_C_K0AA:
				bia_q <= akf_pkg::sat32(66'(bia_q) + 66'(p_sh));
			akf_pkg::ST_C_K0AB: t_qa_q <= p_sh;   // K0*aa'
			akf_pkg::ST_C_K1AA: t_bb_q <= p_sh;   // K0*ab'
			akf_pkg::ST_C_K1AB: t_ang_q <= p_sh;  // K1*aa'
			akf_pkg::ST_STORE: begin
				aa_q <= akf_pkg::sat32(66'(aa_q) - 66'(t_qa_q));
				ab_q <= akf_pkg::sat32(66'(ab_q) - 66'(t_bb_q));
				ba_q <= akf_pkg::sat32(66'(ba_q) - 66'(t_ang_q));
				bb_q <= akf_pkg::sat32(66'(bb_q) - 66'(p_sh));
			end
			default: ;
		endcase
	end

	// per-axis state, written back once the item is finished
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < akf_pkg::AXES; i++) begin
				ang_r[i] <= '0; bia_r[i] <= '0; aa_r[i] <= '0;
				ab_r[i]  <= '0; ba_r[i]  <= '0; bb_r[i] <= '0;
			end
		end else if (st_q == akf_pkg::ST_OUT && !out_stall) begin
			ang_r[ax_q] <= ang_q;
			bia_r[ax_q] <= bia_q;
			aa_r[ax_q]  <= aa_q;
			ab_r[ax_q]  <= ab_q;
			ba_r[ax_q]  <= ba_q;
			bb_r[ax_q]  <= bb_q;
		end
	end

	assign axis_out       = ax_q;
	assign filtered_angle = ang_q;
	assign estimated_bias = bia_q;

	// no request is taken while a result waits
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("request accepted while busy");

	// a result appears only after the store step
	a_out_after_store: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(st_q) == akf_pkg::ST_STORE)
		else $error("result without store step");

	// divider finishes only while waiting on it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		dv_done |-> (st_q == akf_pkg::ST_WAIT0 || st_q == akf_pkg::ST_WAIT1))
		else $error("divider done out of step");

endmodule

FILE: verif/tb_angle_kalman_filter_three_axis.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_angle_kalman_filter_three_axis
// Drives angle/rate/time-step requests into the three-axis angle/bias Kalman
// filter with random gaps and output stalls. A fixed-point predictor checks
// every filtered angle and bias estimate. The noise registers are set to
// several values between phases.
//------------------------------------------------------------------------------
module tb_angle_kalman_filter_three_axis;

	localparam int WDOG_LIMIT = 3000;
	localparam int DRAIN_CYC  = 300;
	localparam int HOLD_CYC   = 500;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic [1:0]         ax;
		logic signed [31:0] ang;
		logic signed [31:0] bias;
	} kf_result_t;

	// per-axis filter state and noise registers; predicts each result
	class kf_scoreboard;
		wide_t      ang_st[akf_pkg::AXES], bias_st[akf_pkg::AXES];
		wide_t      caa[akf_pkg::AXES], cab[akf_pkg::AXES];
		wide_t      cba[akf_pkg::AXES], cbb[akf_pkg::AXES];
		wide_t      q_ang, q_bias, r_meas;
		kf_result_t pending_q[$];
		int         errors;

		function new();
			q_ang  = akf_pkg::QA_RST;
			q_bias = akf_pkg::QB_RST;
			r_meas = akf_pkg::RM_RST;
			errors = 0;
			for (int i = 0; i < akf_pkg::AXES; i++) begin
				ang_st[i] = 0; bias_st[i] = 0;
				caa[i] = 0; cab[i] = 0; cba[i] = 0; cbb[i] = 0;
			end
		endfunction

		function wide_t sat(wide_t v);
			if (v > 128'sd2147483647) return 128'sd2147483647;
			if (v < -128'sd2147483648) return -128'sd2147483648;
			return v;
		endfunction

		function void set_reg(logic [1:0] idx, logic [30:0] val);
			case (idx)
				akf_pkg::REG_QA: q_ang = val;
				akf_pkg::REG_QB: q_bias = val;
				akf_pkg::REG_RM: r_meas = val;
				default: ;
			endcase
		endfunction

		// one accepted request: predict, form gains, correct, queue the result
		function void note_request(logic [1:0] ax, logic signed [31:0] meas,
				logic signed [31:0] rate, logic [23:0] dt_in);
			wide_t ang, bia, aa, ab, ba, bb, paa, pab, k0, k1, e, s, dbb, dt, rt, ms;
			kf_result_t r;
			if (ax >= akf_pkg::AXES)
				return;
			dt = dt_in; rt = rate; ms = meas;
			ang = ang_st[ax]; bia = bias_st[ax];
			aa = caa[ax]; ab = cab[ax]; ba = cba[ax]; bb = cbb[ax];
			// prediction
			ang = sat(ang + ((dt * (rt - bia)) >>> 24));
			dbb = (dt * bb) >>> 24;
			aa = sat(aa + ((-(dt * (ab + ba))) >>> 24) + ((q_ang * dt) >>> 24));
			ab = sat(ab - dbb);
			ba = sat(ba - dbb);
			bb = sat(bb + ((q_bias * dt) >>> 24));
			// gains, zero when the innovation variance is zero
			s = aa + r_meas;
			k0 = (s == 0) ? 0 : sat((aa <<< 24) / s);
			k1 = (s == 0) ? 0 : sat((ba <<< 24) / s);
			// correction against pre-update covariance
			e = ms - ang;
			ang = sat(ang + ((k0 * e) >>> 24));
			bia = sat(bia + ((k1 * e) >>> 24));
			paa = aa; pab = ab;
			aa = sat(paa - ((k0 * paa) >>> 24));
			ab = sat(pab - ((k0 * pab) >>> 24));
			ba = sat(ba - ((k1 * paa) >>> 24));
			bb = sat(bb - ((k1 * pab) >>> 24));
			ang_st[ax] = ang; bias_st[ax] = bia;
			caa[ax] = aa; cab[ax] = ab; cba[ax] = ba; cbb[ax] = bb;
			r.ax = ax; r.ang = ang[31:0]; r.bias = bia[31:0];
			pending_q.push_back(r);
		endfunction

		function void check_result(logic [1:0] ax, logic signed [31:0] ang,
				logic signed [31:0] bias);
			kf_result_t x;
			if (pending_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: axis %0d angle %0d bias %0d", ax, ang, bias);
				return;
			end
			x = pending_q.pop_front();
			if (x.ax !== ax || x.ang !== ang || x.bias !== bias) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp axis %0d angle %0d bias %0d, got %0d %0d %0d",
						x.ax, x.ang, x.bias, ax, ang, bias);
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [30:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         axis;
	logic signed [31:0] measured_angle;
	logic signed [31:0] gyro_rate;
	logic [23:0]        time_step;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         axis_out;
	logic signed [31:0] filtered_angle;
	logic signed [31:0] estimated_bias;

	kf_scoreboard sb = new();
	bit quiet;      // no idling on either side
	bit hold_req;   // receiver long hold-off request
	int idle_cnt = 0;

	angle_kalman_filter_three_axis i_dut (.*);

	always #2 clk = ~clk;

	// watchdog: cycles without any request or result moving
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WDOG_LIMIT) begin
			$display("tb_angle_kalman_filter_three_axis NOT OK");
			$finish;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(axis_out, filtered_angle, estimated_bias);
	end

	// receiver: random stall per result, plus the long hold-off
	initial begin
		int n;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYC) @(posedge clk);
				hold_req = 0;
			end
			n = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid && !hold_req);
		end
	end

	task automatic send_request(logic [1:0] ax, logic signed [31:0] meas,
			logic signed [31:0] rate, logic [23:0] dt);
		int gap;
		gap = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		axis           <= ax;
		measured_angle <= meas;
		gyro_rate      <= rate;
		time_step      <= dt;
		do @(posedge clk); while (in_stall);
		sb.note_request(ax, meas, rate, dt);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
	endtask

	// noise registers are written only with the filter idle
	task automatic write_reg(logic [1:0] idx, logic [30:0] val);
		wait_drained();
		repeat (DRAIN_CYC) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	function automatic logic signed [31:0] rand_angle();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $signed($urandom_range(0, 360 << 16)) - (180 << 16);
			2: return $signed($urandom_range(0, 1 << 16)) - (1 << 15);
			default: return {32{$urandom_range(0, 1) == 1}} ^ $urandom_range(0, 255);
		endcase
	endfunction

	function automatic logic [23:0] rand_step();
		case ($urandom_range(0, 5))
			0: return 24'($urandom);
			1: return 24'd0;
			default: return 24'($urandom_range(0, 335544));
		endcase
	endfunction

	task automatic random_phase(int count);
		logic [1:0] ax;
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			ax = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
			send_request(ax, rand_angle(), rand_angle(), rand_step());
		end
	endtask

	initial begin
		cfg_we         <= 1'b0;
		cfg_index      <= akf_pkg::REG_QA;
		cfg_data       <= '0;
		in_valid       <= 1'b0;
		axis           <= '0;
		measured_angle <= '0;
		gyro_rate      <= '0;
		time_step      <= '0;
		quiet          = 0;
		hold_req       = 0;
		arst_n         = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, every axis, dropped axis
		send_request(2'd0, 32'sh00000000, 32'sh00000000, 24'd0);
		send_request(2'd1, 32'sh7fffffff, 32'sh7fffffff, 24'hffffff);
		send_request(2'd2, 32'sh80000000, 32'sh80000000, 24'hffffff);
		send_request(2'd3, 32'sh7fffffff, 32'sh80000000, 24'hffffff);
		send_request(2'd0, 32'sh005a0000, 32'shffff0000, 24'd167772);
		send_request(2'd1, 32'sh80000000, 32'sh7fffffff, 24'hffffff);
		send_request(2'd2, 32'sh7fffffff, 32'sh00000000, 24'd1);
		send_request(2'd0, 32'shffa60000, 32'sh7fffffff, 24'hffffff);
		send_request(2'd3, 32'sh00000000, 32'sh00000000, 24'd0);
		send_request(2'd1, 32'sh00000001, 32'shffffffff, 24'h800000);

		// long output hold-off while requests keep coming
		hold_req = 1;
		for (int i = 0; i < 5; i++)
			send_request(2'($urandom_range(0, 2)), rand_angle(), rand_angle(), rand_step());
		random_phase(160);

		// largest noise values
		write_reg(akf_pkg::REG_QA, 31'h7fffffff);
		write_reg(akf_pkg::REG_QB, 31'h7fffffff);
		write_reg(akf_pkg::REG_RM, 31'h7fffffff);
		random_phase(160);

		// zero noise: zero innovation variance reachable
		write_reg(akf_pkg::REG_QA, 31'd0);
		write_reg(akf_pkg::REG_QB, 31'd0);
		write_reg(akf_pkg::REG_RM, 31'd0);
		send_request(2'd0, 32'sh00010000, 32'sh00010000, 24'd0);
		send_request(2'd2, 32'sh7fffffff, 32'sh80000000, 24'hffffff);
		random_phase(150);

		// sender pause until everything is back
		wait_drained();
		write_reg(akf_pkg::REG_RM, 31'd1);
		random_phase(150);

		write_reg(akf_pkg::REG_QA, 31'($urandom));
		write_reg(akf_pkg::REG_QB, 31'($urandom_range(0, 1 << 20)));
		write_reg(akf_pkg::REG_RM, 31'($urandom_range(1, 1 << 22)));
		random_phase(200);

		wait_drained();
		repeat (DRAIN_CYC) @(posedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("tb_angle_kalman_filter_three_axis OK");
		else
			$display("tb_angle_kalman_filter_three_axis NOT OK");
		$finish;
	end

endmodule
